// ===== src/zbpa_pkg.sv =====
// ----------------------------------------------------------------------------
// zbpa_pkg
// Shared constants and types of the zoned buddy page allocator.
// ----------------------------------------------------------------------------
package zbpa_pkg;

  // default geometry
  localparam int NUM_FRAMES_DEF = 65536;
  localparam int TOP_ORDER_DEF  = 10;

  // free page counters and configuration registers
  localparam int                CNT_W   = 17;
  localparam logic [CNT_W-1:0]  CNT_MAX = 17'h1FFFF;
  localparam logic [CNT_W-1:0]  CFG_RST = 17'h10000;

  // commands from the sequencer to the free list heads and zone counters
  typedef struct packed {
    logic head_we;   // write list head at idx
    logic cnt_add;   // saturating add to a zone counter
    logic cnt_sub;   // saturating subtract from a zone counter
    logic cnt_zone;  // 0 DMA32, 1 normal
  } zbpa_list_cmd_t;

endpackage

// ===== src/zbpa_lists.sv =====
// ----------------------------------------------------------------------------
// zbpa_lists
// Free list heads for both zones and all orders, plus the per-zone
// saturating free page counters.
// ----------------------------------------------------------------------------
module zbpa_lists #(
  parameter int NUM_FRAMES = zbpa_pkg::NUM_FRAMES_DEF,
  parameter int TOP_ORDER  = zbpa_pkg::TOP_ORDER_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  zbpa_pkg::zbpa_list_cmd_t              cmd,
  input  logic [$clog2(2*(TOP_ORDER+1))-1:0]    idx,
  input  logic [$clog2(NUM_FRAMES):0]           head_wdata,
  input  logic [(($clog2(NUM_FRAMES)+1) > 18 ? ($clog2(NUM_FRAMES)+1) : 18)-1:0] cnt_val,
  output logic [$clog2(NUM_FRAMES):0]           head_rdata,
  output logic [zbpa_pkg::CNT_W-1:0]            low_free,
  output logic [zbpa_pkg::CNT_W-1:0]            normal_free
);
  import zbpa_pkg::*;

  localparam int AW = $clog2(NUM_FRAMES);
  localparam int FW = AW + 1;
  localparam int XW = (FW > 18) ? FW : 18;
  localparam int LN = 2 * (TOP_ORDER + 1);
  localparam logic [FW-1:0] NIL = FW'(NUM_FRAMES);

  logic [FW-1:0]    head [LN];
  logic [CNT_W-1:0] zcnt [2];
  logic [CNT_W-1:0] cur_cnt;
  logic [XW:0]      sum;
  logic [CNT_W-1:0] add_res;
  logic [CNT_W-1:0] sub_res;

  // saturating counter arithmetic on the selected zone
  always_comb begin
    cur_cnt = zcnt[cmd.cnt_zone];
    sum     = (XW+1)'(cur_cnt) + (XW+1)'(cnt_val);
    add_res = (sum > (XW+1)'(CNT_MAX)) ? CNT_MAX : sum[CNT_W-1:0];
    sub_res = (XW'(cur_cnt) > cnt_val) ? (cur_cnt - cnt_val[CNT_W-1:0]) : '0;
  end

  assign head_rdata  = head[idx];
  assign low_free    = zcnt[0];
  assign normal_free = zcnt[1];

  // head and counter updates
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LN; k++) head[k] <= NIL;
      zcnt[0] <= '0;
      zcnt[1] <= '0;
    end else begin
      if (cmd.head_we) head[idx] <= head_wdata;
      if (cmd.cnt_add) zcnt[cmd.cnt_zone] <= add_res;
      else if (cmd.cnt_sub) zcnt[cmd.cnt_zone] <= sub_res;
    end
  end

endmodule

// ===== src/zoned_buddy_page_allocator_core.sv =====
// ----------------------------------------------------------------------------
// zoned_buddy_page_allocator_core
// Two-zone buddy page allocator: seed, allocate and free of page blocks,
// run by a small sequencer over per-frame flag, order and link memories.
// ----------------------------------------------------------------------------
// throughput: one beat at a time, the next taken only once the result has loaded
// reset: synchronous; a clearing pass marks all frames reserved before the
//   first beat is taken, configuration writes go on
module zoned_buddy_page_allocator_core #(
  parameter int NUM_FRAMES = zbpa_pkg::NUM_FRAMES_DEF,
  parameter int TOP_ORDER  = zbpa_pkg::TOP_ORDER_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data,
  // request beats
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // order[3:0], page_frame[19:4], run_length[36:20],
                                 // zone_mask[38:37], zero pad
  input  logic [1:0]  s_tuser,   // mode[1:0]
  // result beats
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata    // status[2:0], block_frame[18:3],
                                 // low_zone_free_pages[35:19],
                                 // normal_zone_free_pages[52:36], zero pad
);
  import zbpa_pkg::*;

  localparam int AW = $clog2(NUM_FRAMES);
  localparam int FW = AW + 1;
  localparam int XW = (FW > 18) ? FW : 18;
  localparam int LW = $clog2(2 * (TOP_ORDER + 1));
  localparam int IW = TOP_ORDER;
  localparam logic [FW-1:0] NIL    = FW'(NUM_FRAMES);
  localparam logic [XW-1:0] PAGESX = XW'(NUM_FRAMES);
  localparam logic [3:0]    TOPO   = 4'(TOP_ORDER);

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_SEED  = 2'd2;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_NOMEM  = 3'd1;
  localparam logic [2:0] ST_ORDER  = 3'd2;
  localparam logic [2:0] ST_ADDR   = 3'd3;
  localparam logic [2:0] ST_DFREE  = 3'd4;

  localparam logic [1:0] FL_FREE  = 2'd0;
  localparam logic [1:0] FL_ALLOC = 2'd1;
  localparam logic [1:0] FL_RSVD  = 2'd2;
  localparam logic [1:0] FL_INNER = 2'd3;

  typedef enum logic [4:0] {
    CLEAR, IDLE, DONE,
    P_WR, P_LNK, U_WAIT, U_UPD, U_CLR,
    T_SCAN, T_SPLIT, T_FIN,
    F_WAIT, F_CHK, M_TRY, M_WAIT, M_CHK, M_JOIN, M_END,
    K_WAIT, K_CHK, S_SP0, S_SP1, S_ORD, S_FILL, S_PUSH, S_NEXT
  } state_t;

  function automatic logic [LW-1:0] lix(input logic zz, input logic [3:0] oo);
    lix = zz ? (LW'(TOP_ORDER + 1) + LW'(oo)) : LW'(oo);
  endfunction

  function automatic logic [XW-1:0] pow2(input logic [3:0] oo);
    pow2 = XW'(1) << oo;
  endfunction

  state_t state, ret;

  // configuration registers
  logic [16:0] frame_limit, low_zone_end;
  logic [XW-1:0] te, de;

  // item and working registers
  logic [3:0]    in_order;
  logic [XW-1:0] in_pf;
  logic [1:0]    in_mask;
  logic          z, span1;
  logic [3:0]    o, ordarg;
  logic [XW-1:0] blk, bud, cur, send, hi, zlo, zhi;
  logic [IW-1:0] i;
  logic [FW-1:0] fr, hsave;
  logic [LW-1:0] lidx;
  logic [AW-1:0] fa, la;
  logic [AW:0]   clr;
  logic [2:0]    res_status;
  logic [15:0]   res_frame;

  // frame memories
  logic [1:0]    fl_mem  [NUM_FRAMES];
  logic [3:0]    ord_mem [NUM_FRAMES];
  logic [FW-1:0] nx_mem  [NUM_FRAMES];
  logic [FW-1:0] pv_mem  [NUM_FRAMES];
  logic [1:0]    fl_rd;
  logic [3:0]    ord_rd;
  logic [FW-1:0] nx_rd, pv_rd;

  logic          fl_we, ord_we, nx_we, pv_we;
  logic [AW-1:0] fl_wa, ord_wa, nx_wa, pv_wa;
  logic [1:0]    fl_wd;
  logic [3:0]    ord_wd;
  logic [FW-1:0] nx_wd, pv_wd;

  // list heads and counters
  zbpa_list_cmd_t   lcmd;
  logic [LW-1:0]    l_idx;
  logic [FW-1:0]    head_wdata, head_rdata;
  logic [XW-1:0]    cnt_val;
  logic [CNT_W-1:0] low_free, normal_free;

  // decoded request fields
  logic [3:0]    rq_order;
  logic [XW-1:0] rq_pf, rq_end, rq_clip;
  logic [1:0]    rq_mask;

  // helpers
  logic [XW-1:0] split_up, bud_x, nsz, seed_lo1, seed_hi0, next_cur;
  logic [3:0]    o_dn;

  assign rq_order = s_tdata[3:0];
  assign rq_pf    = XW'(s_tdata[19:4]);
  assign rq_end   = rq_pf + XW'(s_tdata[36:20]);
  assign rq_clip  = (rq_end > te) ? te : rq_end;
  assign rq_mask  = s_tdata[38:37];

  assign te = (XW'(frame_limit) > PAGESX) ? PAGESX : XW'(frame_limit);
  assign de = (XW'(low_zone_end) < te) ? XW'(low_zone_end) : te;

  assign o_dn     = o - 4'd1;
  assign split_up = blk + pow2(o_dn);
  assign bud_x    = blk ^ pow2(o);
  assign nsz      = XW'(2) << o;
  assign seed_hi0 = (send < de) ? send : de;
  assign seed_lo1 = (in_pf > de) ? in_pf : de;
  assign next_cur = cur + pow2(o);

  assign s_tready = (state == IDLE);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_limit  <= CFG_RST;
      low_zone_end <= CFG_RST;
    end else if (cfg_we) begin
      if (cfg_index) low_zone_end <= cfg_data;
      else frame_limit <= cfg_data;
    end
  end

  // frame memory ports, registered read
  always_ff @(posedge clk) begin
    if (fl_we) fl_mem[fl_wa] <= fl_wd;
    fl_rd <= fl_mem[fa];
  end

  always_ff @(posedge clk) begin
    if (ord_we) ord_mem[ord_wa] <= ord_wd;
    ord_rd <= ord_mem[fa];
  end

  always_ff @(posedge clk) begin
    if (nx_we) nx_mem[nx_wa] <= nx_wd;
    nx_rd <= nx_mem[la];
  end

  always_ff @(posedge clk) begin
    if (pv_we) pv_mem[pv_wa] <= pv_wd;
    pv_rd <= pv_mem[la];
  end

  // memory writes and list commands per sequencer step
  always_comb begin
    fl_we = 1'b0;  fl_wa = fr[AW-1:0];  fl_wd = FL_FREE;
    ord_we = 1'b0; ord_wa = fr[AW-1:0]; ord_wd = ordarg;
    nx_we = 1'b0;  nx_wa = fr[AW-1:0];  nx_wd = NIL;
    pv_we = 1'b0;  pv_wa = fr[AW-1:0];  pv_wd = NIL;
    lcmd = '0;
    l_idx = lidx;
    head_wdata = fr;
    cnt_val = pow2(in_order);
    case (state)
      CLEAR: begin
        fl_we = 1'b1;  fl_wa = clr[AW-1:0];  fl_wd = FL_RSVD;
        ord_we = 1'b1; ord_wa = clr[AW-1:0]; ord_wd = 4'd0;
      end
      P_WR: begin
        fl_we = 1'b1;
        ord_we = 1'b1;
        nx_we = 1'b1; nx_wd = head_rdata;
        pv_we = 1'b1;
        lcmd.head_we = 1'b1;
      end
      P_LNK: begin
        pv_we = (hsave < NIL);
        pv_wa = hsave[AW-1:0];
        pv_wd = fr;
      end
      U_UPD: begin
        nx_we = (pv_rd < NIL); nx_wa = pv_rd[AW-1:0]; nx_wd = nx_rd;
        pv_we = (nx_rd < NIL); pv_wa = nx_rd[AW-1:0]; pv_wd = pv_rd;
        lcmd.head_we = (pv_rd >= NIL);
        head_wdata = nx_rd;
      end
      U_CLR: begin
        nx_we = 1'b1;
        pv_we = 1'b1;
      end
      T_SCAN: l_idx = lix(z, o);
      T_FIN: begin
        fl_we = 1'b1;  fl_wa = blk[AW-1:0];  fl_wd = FL_ALLOC;
        ord_we = 1'b1; ord_wa = blk[AW-1:0]; ord_wd = in_order;
        lcmd.cnt_sub = 1'b1;
        lcmd.cnt_zone = z;
      end
      F_CHK: begin
        lcmd.cnt_add = (fl_rd == FL_ALLOC);
        lcmd.cnt_zone = z;
      end
      M_JOIN: begin
        fl_we = 1'b1;
        fl_wa = (bud > blk) ? bud[AW-1:0] : blk[AW-1:0];
        fl_wd = FL_INNER;
      end
      S_SP0: begin
        lcmd.cnt_add = (in_pf < de);
        lcmd.cnt_zone = 1'b0;
        cnt_val = seed_hi0 - in_pf;
      end
      S_SP1: begin
        lcmd.cnt_add = (send > de);
        lcmd.cnt_zone = 1'b1;
        cnt_val = send - seed_lo1;
      end
      S_FILL: begin
        fl_we = 1'b1;
        fl_wa = AW'(cur + XW'(i));
        fl_wd = FL_INNER;
      end
      default: ;
    endcase
  end

  zbpa_lists #(
    .NUM_FRAMES (NUM_FRAMES),
    .TOP_ORDER  (TOP_ORDER)
  ) u_lists (
    .clk         (clk),
    .rst         (rst),
    .cmd         (lcmd),
    .idx         (l_idx),
    .head_wdata  (head_wdata),
    .cnt_val     (cnt_val),
    .head_rdata  (head_rdata),
    .low_free    (low_free),
    .normal_free (normal_free)
  );

  // sequencer, result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= CLEAR;
      clr      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != DONE) m_tvalid <= 1'b0;
      case (state)
        // mark every frame reserved
        CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == (AW+1)'(NUM_FRAMES - 1)) state <= IDLE;
        end

        // take a request beat and dispatch on its mode
        IDLE: begin
          if (s_tvalid) begin
            in_order   <= rq_order;
            in_pf      <= rq_pf;
            in_mask    <= rq_mask;
            o          <= rq_order;
            res_status <= ST_OK;
            res_frame  <= '0;
            span1      <= 1'b0;
            case (s_tuser)
              MODE_ALLOC: begin
                if (rq_order > TOPO) begin
                  res_status <= ST_ORDER;
                  state <= DONE;
                end else if (rq_mask[1] && te > de) begin
                  z <= 1'b1;
                  state <= T_SCAN;
                end else if (rq_mask[0]) begin
                  z <= 1'b0;
                  state <= T_SCAN;
                end else begin
                  res_status <= ST_NOMEM;
                  state <= DONE;
                end
              end
              MODE_FREE: begin
                if (rq_order > TOPO) begin
                  res_status <= ST_ORDER;
                  state <= DONE;
                end else if ((rq_pf & (pow2(rq_order) - XW'(1))) != '0 || rq_pf >= te) begin
                  res_status <= ST_ADDR;
                  state <= DONE;
                end else begin
                  z   <= (rq_pf >= de);
                  zlo <= (rq_pf < de) ? '0 : de;
                  zhi <= (rq_pf < de) ? de : te;
                  blk <= rq_pf;
                  fa  <= rq_pf[AW-1:0];
                  state <= F_WAIT;
                end
              end
              MODE_SEED: begin
                if (rq_pf >= rq_clip) begin
                  state <= DONE;
                end else begin
                  cur  <= rq_pf;
                  send <= rq_clip;
                  fa   <= rq_pf[AW-1:0];
                  state <= K_WAIT;
                end
              end
              default: state <= DONE;
            endcase
          end
        end

        // list push: link the frame in front of the head
        P_WR: begin
          hsave <= head_rdata;
          state <= P_LNK;
        end
        P_LNK: state <= ret;

        // list unlink: read links, patch neighbours, clear own links
        U_WAIT: state <= U_UPD;
        U_UPD:  state <= U_CLR;
        U_CLR:  state <= ret;

        // allocate: find the smallest non-empty order at or above the request in this zone
        T_SCAN: begin
          if (head_rdata < NIL) begin
            blk  <= XW'(head_rdata);
            fr   <= head_rdata;
            la   <= head_rdata[AW-1:0];
            lidx <= lix(z, o);
            ret  <= T_SPLIT;
            state <= U_WAIT;
          end else if (o == TOPO) begin
            if (z && in_mask[0]) begin
              z <= 1'b0;
              o <= in_order;
            end else begin
              res_status <= ST_NOMEM;
              state <= DONE;
            end
          end else begin
            o <= o + 4'd1;
          end
        end
        // hand back the upper halves down to the requested order
        T_SPLIT: begin
          if (o > in_order) begin
            o <= o_dn;
            if (split_up < PAGESX) begin
              fr     <= FW'(split_up);
              ordarg <= o_dn;
              lidx   <= lix(z, o_dn);
              ret    <= T_SPLIT;
              state  <= P_WR;
            end
          end else begin
            state <= T_FIN;
          end
        end
        T_FIN: begin
          res_frame <= blk[15:0];
          state <= DONE;
        end

        // free: double free check
        F_WAIT: state <= F_CHK;
        F_CHK: begin
          if (fl_rd != FL_ALLOC) begin
            res_status <= ST_DFREE;
            state <= DONE;
          end else begin
            state <= M_TRY;
          end
        end
        // merge with a free buddy of equal order
        M_TRY: begin
          if (o < TOPO && bud_x < zhi && bud_x >= zlo && bud_x < PAGESX) begin
            bud <= bud_x;
            fa  <= bud_x[AW-1:0];
            state <= M_WAIT;
          end else begin
            state <= M_END;
          end
        end
        M_WAIT: state <= M_CHK;
        M_CHK: begin
          if (fl_rd != FL_FREE || ord_rd != o) begin
            state <= M_END;
          end else begin
            fr   <= FW'(bud);
            la   <= bud[AW-1:0];
            lidx <= lix(z, o);
            ret  <= M_JOIN;
            state <= U_WAIT;
          end
        end
        M_JOIN: begin
          if (bud < blk) blk <= bud;
          o <= o + 4'd1;
          state <= M_TRY;
        end
        M_END: begin
          fr     <= FW'(blk);
          ordarg <= o;
          lidx   <= lix(z, o);
          ret    <= DONE;
          state  <= P_WR;
        end

        // seed: every page of the run must be reserved
        K_WAIT: state <= K_CHK;
        K_CHK: begin
          if (fl_rd != FL_RSVD) begin
            res_status <= ST_ADDR;
            state <= DONE;
          end else if (cur + XW'(1) == send) begin
            state <= S_SP0;
          end else begin
            cur <= cur + XW'(1);
            fa  <= AW'(cur + XW'(1));
            state <= K_WAIT;
          end
        end
        // span set-up per zone
        S_SP0: begin
          if (in_pf < de) begin
            z   <= 1'b0;
            cur <= in_pf;
            hi  <= seed_hi0;
            o   <= 4'd0;
            state <= S_ORD;
          end else begin
            state <= S_SP1;
          end
        end
        S_SP1: begin
          if (send > de) begin
            z     <= 1'b1;
            cur   <= seed_lo1;
            hi    <= send;
            o     <= 4'd0;
            span1 <= 1'b1;
            state <= S_ORD;
          end else begin
            state <= DONE;
          end
        end
        // grow the block while it stays aligned and inside the span
        S_ORD: begin
          if (o < TOPO && nsz <= hi - cur && (cur & (nsz - XW'(1))) == '0) begin
            o <= o + 4'd1;
          end else begin
            i <= IW'(1);
            state <= (o == 4'd0) ? S_PUSH : S_FILL;
          end
        end
        S_FILL: begin
          if (XW'(i) == pow2(o) - XW'(1)) state <= S_PUSH;
          else i <= i + IW'(1);
        end
        S_PUSH: begin
          fr     <= FW'(cur);
          ordarg <= o;
          lidx   <= lix(z, o);
          ret    <= S_NEXT;
          state  <= P_WR;
        end
        S_NEXT: begin
          cur <= next_cur;
          o   <= 4'd0;
          if (next_cur < hi) state <= S_ORD;
          else if (span1) state <= DONE;
          else state <= S_SP1;
        end

        // load the result beat
        DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {3'd0, normal_free, low_free, res_frame, res_status};
            state    <= IDLE;
          end
        end

        default: state <= IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // a taken beat closes the input until its result is out
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request taken while busy");

  // result beats only come from the load step
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == DONE))
    else $error("result without load step");

  // failed items carry no block frame
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[2:0] != ST_OK) |-> (m_tdata[18:3] == 16'd0))
    else $error("frame on failed result");

  // only real frames are pushed onto a free list
  assert property (@(posedge clk) disable iff (rst)
    (state == P_WR) |-> (fr < NIL))
    else $error("push of invalid frame");
`endif

endmodule
